// File: design/sacc_pkg.sv
// Package for the set-associative cache controller: constants, payload types, codes.
// No dependencies.
`default_nettype none
package sacc_pkg;
    localparam int BLOCK_BYTES_D = 64;
    localparam int SETS_D        = 64;
    localparam int WAYS_D        = 4;
    localparam int RRPV_BITS_D   = 2;

    localparam logic [2:0] CFG_WRITE_BACK   = 3'd0;
    localparam logic [2:0] CFG_WRITE_ALLOC  = 3'd1;
    localparam logic [2:0] CFG_REPL_MODE    = 3'd2;
    localparam logic [2:0] CFG_HIT_LATENCY  = 3'd3;
    localparam logic [2:0] CFG_MISS_LATENCY = 3'd4;

    localparam logic [1:0] REPL_LRU  = 2'd0;
    localparam logic [1:0] REPL_FIFO = 2'd1;
    localparam logic [1:0] REPL_RRIP = 2'd2;

    localparam logic [1:0] FWD_NONE    = 2'd0;
    localparam logic [1:0] FWD_THROUGH = 2'd1;
    localparam logic [1:0] FWD_BYTE    = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [1:0]  way;
        logic        fill_request;
        logic [31:0] fill_block_address;
        logic        writeback_request;
        logic [31:0] writeback_block_address;
        logic [1:0]  forward_write;
        logic [10:0] charged_cycles;
    } t_rsp;

    typedef struct packed {
        logic       write_back;
        logic       write_allocate;
        logic [1:0] replacement_mode;
        logic [7:0] hit_latency;
        logic [9:0] miss_latency;
    } t_cfg;
endpackage
`default_nettype wire

// File: design/sacc_cfg.sv
// Configuration register bank of the cache controller.
// Depends on sacc_pkg.
`default_nettype none
module sacc_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [9:0]     i_cfg_data,
    output sacc_pkg::t_cfg      o_cfg
);
    sacc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_back       <= 1'b1;
            r_cfg.write_allocate   <= 1'b1;
            r_cfg.replacement_mode <= sacc_pkg::REPL_LRU;
            r_cfg.hit_latency      <= 8'd1;
            r_cfg.miss_latency     <= 10'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sacc_pkg::CFG_WRITE_BACK:   r_cfg.write_back       <= i_cfg_data[0];
                sacc_pkg::CFG_WRITE_ALLOC:  r_cfg.write_allocate   <= i_cfg_data[0];
                sacc_pkg::CFG_REPL_MODE:    r_cfg.replacement_mode <= i_cfg_data[1:0];
                sacc_pkg::CFG_HIT_LATENCY:  r_cfg.hit_latency      <= i_cfg_data[7:0];
                sacc_pkg::CFG_MISS_LATENCY: r_cfg.miss_latency     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: design/set_assoc_cache_controller_unit.sv
// Top level of the set-associative cache tag directory and controller.
// Depends on sacc_pkg and sacc_cfg.
//
// Usage: an access item (operation, address) enters on i_req_valid/o_req_ready;
// one result item leaves on o_rsp_valid/i_rsp_ready. Each item reads one whole
// set (all ways) from the tag memory in the cycle after acceptance, decides
// hit/victim in the next and, once the output register is free, writes the set
// back and registers the result; a new item is accepted only once the previous
// item has registered its result, as the controller takes one item at a time.
// Reset clears a valid bit for each line. The FIFO pointer shares the set's
// memory word and reads as zero while no way of the set is valid; tags, stamps
// and RRPV of an invalid line are never used.
// A stalled result holds in the output register; a new item is accepted while
// it waits and is processed up to the point of writing its own result.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data.
`default_nettype none
module set_assoc_cache_controller_unit #(
    parameter int BLOCK_BYTES = sacc_pkg::BLOCK_BYTES_D,
    parameter int SETS        = sacc_pkg::SETS_D,
    parameter int WAYS        = sacc_pkg::WAYS_D,
    parameter int RRPV_BITS   = sacc_pkg::RRPV_BITS_D
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire sacc_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output sacc_pkg::t_rsp      o_rsp,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_idx,
    input  wire logic [9:0]     i_cfg_data
);
    localparam int OB  = $clog2(BLOCK_BYTES);
    localparam int IB  = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int SW  = (SETS > 1) ? IB : 1;
    localparam int TB  = 32 - OB - IB;
    localparam int WB  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LW  = TB + 1 + 32 + RRPV_BITS;
    localparam int MW  = WAYS * LW + WB;
    localparam logic [RRPV_BITS-1:0] RMAX = {RRPV_BITS{1'b1}};
    localparam logic [RRPV_BITS-1:0] RINS = RMAX - 1'b1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    sacc_pkg::t_cfg cfg;
    sacc_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    // word = {fifo pointer, ways}; line = {tag, dirty, last_use, rrpv}
    logic [MW-1:0]      r_mem [SETS];
    logic [MW-1:0]      r_rd;
    logic [MW-1:0]      n_wr;
    logic               mem_we;
    logic [WAYS-1:0]    r_valid [SETS];
    logic [WAYS-1:0]    r_vmask;

    logic [1:0]         r_state;
    sacc_pkg::t_req     r_req;
    logic [31:0]        r_count;
    logic               r_out_valid;
    sacc_pkg::t_rsp     r_out;
    sacc_pkg::t_rsp     n_out;

    logic [SW-1:0] req_set;
    logic [TB-1:0] req_tag;
    assign req_tag = r_req.address[31 -: TB];
    generate
        if (SETS > 1) begin : g_set
            assign req_set = r_req.address[OB +: IB];
        end else begin : g_noset
            assign req_set = 1'b0;
        end
    endgenerate

    assign o_req_ready = (r_state == ST_IDLE);
    wire accept = i_req_valid && o_req_ready;
    wire can_finish = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd <= r_mem[req_set];
            r_vmask <= r_valid[req_set];
        end
        if (mem_we) r_mem[req_set] <= n_wr;
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_req;
        if (r_state == ST_EXEC && can_finish) r_out <= n_out;
    end

    always_comb begin
        logic [TB-1:0]        t;
        logic [31:0]          lu, best_lu;
        logic [RRPV_BITS-1:0] rv, top, delta;
        logic [WAYS*RRPV_BITS-1:0] aged;
        logic                 found, inv_found, rr_found;
        logic [WB-1:0]        hw, vw, inv_w, lru_w, rr_w, fifo_cur;
        logic [31:0]          cnt;
        logic                 dirty_v;
        logic [TB-1:0]        tag_v;
        logic [10:0]          cyc;
        n_wr = r_rd;
        n_out = '0;
        mem_we = 1'b0;
        found = 1'b0; hw = '0;
        inv_found = 1'b0; inv_w = '0;
        best_lu = r_rd[RRPV_BITS +: 32]; lru_w = '0;
        top = '0; rr_found = 1'b0; rr_w = '0; aged = '0;
        t = '0; lu = '0; rv = '0; delta = '0;
        vw = '0; dirty_v = 1'b0; tag_v = '0; cyc = '0;
        cnt = r_count + 32'd1;
        fifo_cur = (r_vmask == '0) ? '0 : r_rd[WAYS*LW +: WB];
        n_wr[WAYS*LW +: WB] = fifo_cur;
        for (int w = 0; w < WAYS; w++) begin
            t = r_rd[w*LW + LW-1 -: TB];
            if (r_vmask[w] && t == req_tag && !found) begin
                found = 1'b1; hw = WB'(w);
            end
            if (!r_vmask[w] && !inv_found) begin
                inv_found = 1'b1; inv_w = WB'(w);
            end
            lu = r_rd[w*LW + RRPV_BITS +: 32];
            if (w > 0 && lu < best_lu) begin
                best_lu = lu; lru_w = WB'(w);
            end
            rv = r_rd[w*LW +: RRPV_BITS];
            if (rv > top) top = rv;
        end
        delta = RMAX - top;
        for (int w = 0; w < WAYS; w++) begin
            rv = r_rd[w*LW +: RRPV_BITS] + delta;
            aged[w*RRPV_BITS +: RRPV_BITS] = rv;
            if (rv == RMAX && !rr_found) begin
                rr_found = 1'b1; rr_w = WB'(w);
            end
        end
        if (found) begin
            vw = hw;
            mem_we = 1'b1;
            n_wr[vw*LW + RRPV_BITS +: 32] = cnt;
            n_wr[vw*LW +: RRPV_BITS] = '0;
            cyc = 11'(cfg.hit_latency);
            if (r_req.operation) begin
                n_wr[vw*LW + RRPV_BITS + 32] = 1'b1;
                if (!cfg.write_back) begin
                    n_out.forward_write = sacc_pkg::FWD_THROUGH;
                    cyc = cyc + 11'(cfg.miss_latency);
                end
            end
            n_out.hit = 1'b1;
            n_out.way = 2'(vw);
        end else if (r_req.operation && !cfg.write_allocate) begin
            vw = '0;
            cyc = 11'(cfg.miss_latency);
            n_out.forward_write = sacc_pkg::FWD_BYTE;
        end else begin
            mem_we = 1'b1;
            cyc = 11'(cfg.miss_latency);
            if (inv_found) vw = inv_w;
            else begin
                case (cfg.replacement_mode)
                    sacc_pkg::REPL_LRU:  vw = lru_w;
                    sacc_pkg::REPL_FIFO: begin
                        vw = fifo_cur;
                        n_wr[WAYS*LW +: WB] = (fifo_cur == WB'(WAYS-1)) ? '0
                                                                        : fifo_cur + 1'b1;
                    end
                    sacc_pkg::REPL_RRIP: begin
                        vw = rr_w;
                        for (int w = 0; w < WAYS; w++)
                            n_wr[w*LW +: RRPV_BITS] = aged[w*RRPV_BITS +: RRPV_BITS];
                    end
                    default: vw = '0;
                endcase
            end
            dirty_v = r_rd[vw*LW + RRPV_BITS + 32];
            tag_v = r_rd[vw*LW + LW-1 -: TB];
            if (cfg.write_back && r_vmask[vw] && dirty_v) begin
                n_out.writeback_request = 1'b1;
                n_out.writeback_block_address = (32'(tag_v) << (OB + IB))
                                              | (32'(req_set) << OB);
                cyc = cyc + 11'(cfg.miss_latency);
            end
            n_wr[vw*LW +: LW] = {req_tag, r_req.operation, cnt, RINS};
            n_out.way = 2'(vw);
            n_out.fill_request = 1'b1;
            n_out.fill_block_address = {r_req.address[31:OB], OB'(0)};
        end
        n_out.charged_cycles = cyc;
        if (!(r_state == ST_EXEC && can_finish)) mem_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            if (o_rsp_valid && i_rsp_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (accept) r_state <= ST_READ;
                ST_READ: r_state <= ST_EXEC;
                ST_EXEC: if (can_finish) begin
                    r_state <= ST_IDLE;
                    r_out_valid <= 1'b1;
                    r_count <= r_count + 32'd1;
                    if (mem_we) r_valid[req_set][n_out.way[WB-1:0]] <= 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp = r_out;

`ifndef SYNTHESIS
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_req_ready) else $error("accepted while busy");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> o_rsp_valid && $stable(o_rsp))
        else $error("result dropped");
    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_rsp.hit && o_rsp.fill_request)) else $error("hit with fill");
`endif
endmodule
`default_nettype wire
